// ===== hw/rtl/twaf_pkg.sv =====
// Shared types and constants of the trimmed window average filter.
// No dependencies; every other file of the block refers to it by scoped names.
package twaf_pkg;

	localparam int AXIS_W   = 2;
	localparam int SAMPLE_W = 16;
	localparam int OFFSET_W = 13;
	localparam int VALUE_W  = 17;
	localparam int RESULT_W = 20;
	localparam int CFG_IDX_W = 2;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;

	// Axis codes
	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	// Per-axis ring pointers are kept for every code the axis field can carry
	localparam int AXIS_SLOTS = 4;

	typedef enum logic [1:0] {
		ACC_INIT,
		ACC_ADD,
		ACC_SUB_HI,
		ACC_SUB_LO
	} acc_op_t;

	typedef struct packed {
		logic    en;
		acc_op_t op;
	} acc_ctrl_t;

endpackage

// ===== hw/rtl/twaf_ifs.sv =====
// Valid/ready channel interfaces of the trimmed window average filter.
// Depends on twaf_pkg for the field widths.
interface twaf_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [twaf_pkg::AXIS_W-1:0]          axis;
	logic signed [twaf_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output axis, output sample, input ready);
	modport sink (input valid, input axis, input sample, output ready);
endinterface

interface twaf_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [twaf_pkg::AXIS_W-1:0]          axis_out;
	logic signed [twaf_pkg::RESULT_W-1:0] average_eighths;

	modport source (output valid, output axis_out, output average_eighths, input ready);
	modport sink (input valid, input axis_out, input average_eighths, output ready);
endinterface

// ===== hw/rtl/twaf_mem.sv =====
// Window history memory: one write port, one registered read port,
// per-entry valid bits so that unwritten entries read as zero. Uses twaf_pkg.
module twaf_mem #(
	parameter int DEPTH = 27,
	parameter int AW    = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                we,
	input  logic [AW-1:0]                       waddr,
	input  logic signed [twaf_pkg::VALUE_W-1:0] wdata,
	input  logic                                re,
	input  logic [AW-1:0]                       raddr,
	output logic signed [twaf_pkg::VALUE_W-1:0] rdata
);

	logic signed [twaf_pkg::VALUE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]                    valid_q;
	logic signed [twaf_pkg::VALUE_W-1:0] rdata_q;
	logic                                rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvalid_q <= valid_q[raddr];
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

// ===== hw/rtl/twaf_acc.sv =====
// Shared accumulate/compare unit: running sum, maximum and minimum of the window,
// then trimming of the extremes through the same adder. Uses twaf_pkg.
module twaf_acc #(
	parameter int SUM_W = 22,
	parameter int BIAS  = 4
) (
	input  logic                                clk,
	input  twaf_pkg::acc_ctrl_t                 ctrl,
	input  logic signed [twaf_pkg::VALUE_W-1:0] value,
	output logic signed [SUM_W-1:0]             sum
);

	logic signed [SUM_W-1:0]             sum_q;
	logic signed [twaf_pkg::VALUE_W-1:0] hi_q;
	logic signed [twaf_pkg::VALUE_W-1:0] lo_q;
	logic signed [SUM_W-1:0]             value_ext;
	logic signed [SUM_W-1:0]             add_a;
	logic signed [SUM_W-1:0]             add_b;
	logic                                add_cin;
	logic signed [SUM_W-1:0]             add_y;

	assign value_ext = SUM_W'(value);

	// Single adder: a + b + cin, subtraction as inverted operand plus carry
	always_comb begin
		add_a   = sum_q;
		add_b   = value_ext;
		add_cin = 1'b0;
		case (ctrl.op)
			twaf_pkg::ACC_INIT: begin
				add_a = SUM_W'(BIAS);
			end
			twaf_pkg::ACC_ADD: begin
				add_b = value_ext;
			end
			twaf_pkg::ACC_SUB_HI: begin
				add_b   = ~SUM_W'(hi_q);
				add_cin = 1'b1;
			end
			twaf_pkg::ACC_SUB_LO: begin
				add_b   = ~SUM_W'(lo_q);
				add_cin = 1'b1;
			end
			default: begin
				add_b = value_ext;
			end
		endcase
		add_y = add_a + add_b + SUM_W'(add_cin);
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			sum_q <= add_y;
			if (ctrl.op == twaf_pkg::ACC_INIT) begin
				hi_q <= value;
				lo_q <= value;
			end else if (ctrl.op == twaf_pkg::ACC_ADD) begin
				if (value > hi_q) begin
					hi_q <= value;
				end
				if (value < lo_q) begin
					lo_q <= value;
				end
			end
		end
	end

	assign sum = sum_q;

endmodule

// ===== hw/rtl/trimmed_window_average_filter.sv =====
// Top level of the trimmed window average filter: sequencer, offset registers
// and output register. Uses twaf_pkg, twaf_ifs, twaf_mem and twaf_acc.
//
// Usage:
//   samples carries one request per accelerometer reading: axis and sample.
//   results carries one request per reading: axis_out and average_eighths, the
//   sum of the newest WINDOW offset-corrected values of that axis with one
//   largest and one smallest removed, plus (WINDOW-2)/2.
//   The user writes offsets through cfg_we/cfg_index/cfg_data only while the block idles; the block does not check it.
// Timing:
//   A request is taken only when the sequencer is idle. It then walks the
//   axis history one memory entry per cycle through the shared accumulator:
//   sum/max/min over the new value and the entries in S_RUN, the trims in
//   S_HI and S_LO, then S_OUT loads the output register. The next request is
//   taken only once the sequencer is back in idle, after S_OUT. The single
//   read port of the history memory makes the walk one entry at a time.
//   An axis code with no window skips the walk: it goes from idle straight
//   to S_OUT, where its zero result is loaded into the output register.
// Reset:
//   All histories read as zero and all offsets are zero; no clearing pass.
// Stall:
//   A finished result waits in the output register; the next request is taken
//   meanwhile, and its result holds in the output cycle until the register frees.
module trimmed_window_average_filter #(
	parameter int WINDOW = 10,
	parameter int AXES   = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	twaf_in_if.sink                              samples,
	twaf_out_if.source                           results,
	input  logic                                 cfg_we,
	input  logic [twaf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [twaf_pkg::OFFSET_W-1:0]        cfg_data
);

	localparam int HIST    = WINDOW - 1;
	localparam int ENTRIES = AXES * HIST;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(HIST + 1);
	localparam int PTR_W   = (HIST > 1) ? $clog2(HIST) : 1;
	localparam int SUM_W   = twaf_pkg::VALUE_W + $clog2(WINDOW) + 1;
	localparam int BIAS    = (WINDOW - 2) / 2;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RUN  = 3'd1;
	localparam logic [2:0] S_HI   = 3'd2;
	localparam logic [2:0] S_LO   = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]                          state_q;
	logic [CNT_W-1:0]                    cnt_q;
	logic [twaf_pkg::AXIS_W-1:0]         axis_q;
	logic signed [twaf_pkg::VALUE_W-1:0] val_q;
	logic                                bad_q;
	logic [PTR_W-1:0]                    ptr_q [twaf_pkg::AXIS_SLOTS];
	logic signed [twaf_pkg::OFFSET_W-1:0] offset_q [3];

	logic                                out_valid_q;
	logic [twaf_pkg::AXIS_W-1:0]         out_axis_q;
	logic signed [twaf_pkg::RESULT_W-1:0] out_avg_q;

	logic                                accept;
	logic                                axis_ok;
	logic                                out_free;
	logic signed [twaf_pkg::OFFSET_W-1:0] offset_sel;
	logic signed [twaf_pkg::VALUE_W-1:0] val_new;
	logic [AW-1:0]                       rd_addr;
	logic [AW-1:0]                       wr_addr;
	logic                                mem_re;
	logic                                mem_we;
	logic signed [twaf_pkg::VALUE_W-1:0] mem_rdata;
	twaf_pkg::acc_ctrl_t                 acc_ctrl;
	logic signed [twaf_pkg::VALUE_W-1:0] acc_value;
	logic signed [SUM_W-1:0]             acc_sum;

	assign samples.ready = (state_q == S_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign axis_ok       = ({30'd0, samples.axis} < 32'(AXES));
	assign out_free      = !out_valid_q || results.ready;

	// Offset of the incoming axis; axes without a register get none
	always_comb begin
		case (samples.axis)
			twaf_pkg::AXIS_X: offset_sel = offset_q[0];
			twaf_pkg::AXIS_Y: offset_sel = offset_q[1];
			twaf_pkg::AXIS_Z: offset_sel = offset_q[2];
			default:          offset_sel = '0;
		endcase
	end

	assign val_new = twaf_pkg::VALUE_W'(samples.sample) + twaf_pkg::VALUE_W'(offset_sel);

	// History of axis a occupies entries a*HIST .. a*HIST+HIST-1 as a ring
	assign rd_addr = AW'(32'(axis_q) * HIST + 32'(cnt_q));
	assign wr_addr = AW'(32'(axis_q) * HIST + 32'(ptr_q[axis_q]));
	assign mem_re  = (state_q == S_RUN) && (32'(cnt_q) < HIST);
	assign mem_we  = (state_q == S_HI);

	// Run cycle 0 seeds the unit with the new value; run cycle k adds entry k-1
	always_comb begin
		acc_ctrl.en = 1'b0;
		acc_ctrl.op = twaf_pkg::ACC_ADD;
		acc_value   = mem_rdata;
		case (state_q)
			S_RUN: begin
				acc_ctrl.en = 1'b1;
				if (cnt_q == '0) begin
					acc_ctrl.op = twaf_pkg::ACC_INIT;
					acc_value   = val_q;
				end
			end
			S_HI: begin
				acc_ctrl.en = 1'b1;
				acc_ctrl.op = twaf_pkg::ACC_SUB_HI;
			end
			S_LO: begin
				acc_ctrl.en = 1'b1;
				acc_ctrl.op = twaf_pkg::ACC_SUB_LO;
			end
			default: begin
				acc_ctrl.en = 1'b0;
			end
		endcase
	end

	twaf_mem #(
		.DEPTH (ENTRIES),
		.AW    (AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (wr_addr),
		.wdata  (val_q),
		.re     (mem_re),
		.raddr  (rd_addr),
		.rdata  (mem_rdata)
	);

	twaf_acc #(
		.SUM_W (SUM_W),
		.BIAS  (BIAS)
	) u_acc (
		.clk   (clk),
		.ctrl  (acc_ctrl),
		.value (acc_value),
		.sum   (acc_sum)
	);

	// Offset registers; writes to indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q[0] <= '0;
			offset_q[1] <= '0;
			offset_q[2] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				twaf_pkg::REG_OFFSET_X: offset_q[0] <= cfg_data;
				twaf_pkg::REG_OFFSET_Y: offset_q[1] <= cfg_data;
				twaf_pkg::REG_OFFSET_Z: offset_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Latch the request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			axis_q <= samples.axis;
			val_q  <= val_new;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			bad_q   <= 1'b0;
			for (int i = 0; i < twaf_pkg::AXIS_SLOTS; i++) begin
				ptr_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						bad_q <= !axis_ok;
						state_q <= axis_ok ? S_RUN : S_OUT;
					end
				end
				S_RUN: begin
					// Hold the counter on the last entry of the walk
					if (32'(cnt_q) == HIST) begin
						state_q <= S_HI;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_HI: begin
					// Overwrite the oldest entry and advance the ring
					if (32'(ptr_q[axis_q]) == HIST - 1) begin
						ptr_q[axis_q] <= '0;
					end else begin
						ptr_q[axis_q] <= ptr_q[axis_q] + 1'b1;
					end
					state_q <= S_LO;
				end
				S_LO: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_axis_q <= axis_q;
			out_avg_q  <= bad_q ? '0 : acc_sum[twaf_pkg::RESULT_W-1:0];
		end
	end

	assign results.valid           = out_valid_q;
	assign results.axis_out        = out_axis_q;
	assign results.average_eighths = out_avg_q;

	// An accepted request always starts work
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("request accepted but sequencer stayed idle");

	// The walk counter never passes the history length
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= HIST)
		else $error("walk counter out of range");

	// Leaving the output cycle always presents a result
	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> results.valid)
		else $error("result not presented after output cycle");

	// An axis without a window is answered with zero
	a_bad_axis_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free && bad_q) |=> results.average_eighths == '0)
		else $error("nonzero result for axis without window");

	// No history write while the walk is reading
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("history read and write in the same cycle");

endmodule

// ===== test/trimmed_window_average_filter_tb.sv =====
// Self-checking testbench for the trimmed window average filter top level.
// Depends on twaf_pkg, the twaf_in_if/twaf_out_if channels and the filter RTL.
// Stimulus is directed plus random runs per axis, checked against a local predictor.
module trimmed_window_average_filter_tb;

	localparam int WINDOW      = 10;
	localparam int AXES        = 3;
	localparam int HIST        = WINDOW - 1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 6;
	localparam int RANDOM_ITEMS_PER_PHASE = 90;
	// Axis code that has no window; the block answers it with zero
	localparam logic [twaf_pkg::AXIS_W-1:0] AXIS_NONE = 2'd3;

	typedef struct {
		logic [twaf_pkg::AXIS_W-1:0]          axis;
		logic signed [twaf_pkg::SAMPLE_W-1:0] sample;
	} sample_req_t;

	typedef struct packed {
		logic [twaf_pkg::AXIS_W-1:0]          axis_out;
		logic signed [twaf_pkg::RESULT_W-1:0] average_eighths;
	} avg_result_t;

	// Content shapes for one random run on a single axis
	typedef enum int {
		STYLE_NOISE,
		STYLE_FLAT,
		STYLE_NEAR,
		STYLE_EDGE
	} sample_style_t;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               cfg_we;
	logic [twaf_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [twaf_pkg::OFFSET_W-1:0]      cfg_data;

	twaf_in_if  samples_if ();
	twaf_out_if results_if ();

	trimmed_window_average_filter #(
		.WINDOW (WINDOW),
		.AXES   (AXES)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_if),
		.results   (results_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor state: offsets and per-axis histories, newest first
	logic signed [twaf_pkg::OFFSET_W-1:0] axis_offset [AXES];
	logic signed [twaf_pkg::VALUE_W-1:0]  axis_history [AXES][HIST];

	sample_req_t pending_samples [$];
	avg_result_t expected_averages [$];

	// Sender and receiver pacing
	int send_burst  = 0;
	int send_gap    = 0;
	int gap_level   = 0;
	int stall_level = 0;
	int rx_open     = 0;
	int rx_stall    = 0;
	logic in_taken  = 1'b0;

	int cycle_count    = 0;
	int error_count    = 0;
	int items_accepted = 0;
	int results_seen   = 0;
	int offaxis_seen   = 0;
	int settings_used  = 1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Work out the result of one request and advance the history of its axis.
	function automatic avg_result_t trim_average(logic [twaf_pkg::AXIS_W-1:0] axis,
			logic signed [twaf_pkg::SAMPLE_W-1:0] sample);
		avg_result_t                         res;
		logic signed [twaf_pkg::VALUE_W-1:0] corrected;
		int                                  total;
		int                                  top;
		int                                  bottom;
		res.axis_out = axis;
		res.average_eighths = '0;
		if (axis >= AXES) return res;
		corrected = sample + axis_offset[axis];
		total  = corrected;
		top    = corrected;
		bottom = corrected;
		for (int k = 0; k < HIST; k++) begin
			total += axis_history[axis][k];
			if (axis_history[axis][k] > top) top = axis_history[axis][k];
			if (axis_history[axis][k] < bottom) bottom = axis_history[axis][k];
		end
		for (int k = HIST - 1; k > 0; k--) axis_history[axis][k] = axis_history[axis][k - 1];
		axis_history[axis][0] = corrected;
		// Drop one largest and one smallest, then add (WINDOW - 2) / 2
		total = total - top - bottom + (WINDOW - 2) / 2;
		res.average_eighths = twaf_pkg::RESULT_W'(total);
		return res;
	endfunction

	// Write one offset register and mirror it in the predictor; only call when idle.
	task automatic write_offset(logic [twaf_pkg::CFG_IDX_W-1:0] index,
			logic signed [twaf_pkg::OFFSET_W-1:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = index;
		cfg_data  = value;
		case (index)
			twaf_pkg::REG_OFFSET_X: axis_offset[twaf_pkg::AXIS_X] = value;
			twaf_pkg::REG_OFFSET_Y: axis_offset[twaf_pkg::AXIS_Y] = value;
			twaf_pkg::REG_OFFSET_Z: axis_offset[twaf_pkg::AXIS_Z] = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic queue_sample(logic [twaf_pkg::AXIS_W-1:0] axis,
			logic signed [twaf_pkg::SAMPLE_W-1:0] sample);
		sample_req_t req;
		req.axis   = axis;
		req.sample = sample;
		pending_samples.push_back(req);
	endtask

	// Queue runs of requests on one axis so the windows fill with related content:
	// flat runs give ties, near runs give small spreads, edge runs hit the limits.
	task automatic queue_random_runs(int count);
		sample_req_t                          req;
		logic [twaf_pkg::AXIS_W-1:0]          run_axis;
		logic signed [twaf_pkg::SAMPLE_W-1:0] base;
		sample_style_t                        style;
		int                                   run_len;
		int                                   left;
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 11) == 0) begin
				run_axis = AXIS_NONE;
				run_len  = $urandom_range(1, 3);
			end else begin
				run_axis = twaf_pkg::AXIS_W'($urandom_range(twaf_pkg::AXIS_X,
					twaf_pkg::AXIS_Z));
				run_len  = $urandom_range(1, 14);
			end
			style = sample_style_t'($urandom_range(STYLE_NOISE, STYLE_EDGE));
			base  = twaf_pkg::SAMPLE_W'($urandom());
			for (int k = 0; k < run_len && left > 0; k++) begin
				req.axis = run_axis;
				case (style)
					STYLE_FLAT: req.sample = base;
					STYLE_NEAR: req.sample = base
						+ twaf_pkg::SAMPLE_W'($urandom_range(0, 4)) - 16'sd2;
					STYLE_EDGE: begin
						case ($urandom_range(0, 3))
							0: req.sample = 16'sh7FFF;
							1: req.sample = 16'sh8000;
							2: req.sample = 16'sh0000;
							default: req.sample = 16'shFFFF;
						endcase
					end
					default: req.sample = twaf_pkg::SAMPLE_W'($urandom());
				endcase
				pending_samples.push_back(req);
				left--;
			end
		end
	endtask

	// Hold until every queued request is accepted and answered, then let the
	// block settle for a little more than its per-item latency.
	task automatic drain();
		while (pending_samples.size() != 0 || samples_if.valid || expected_averages.size() != 0)
			@(posedge clk);
		repeat (WINDOW + 8) @(posedge clk);
	endtask

	// Driver: present requests at the falling edge in bursts separated by gaps,
	// and pace the result channel's ready with its own open/stall pattern.
	always @(negedge clk) begin : drive
		sample_req_t req;
		if (!arst_n) begin
			samples_if.valid <= 1'b0;
			results_if.ready <= 1'b0;
		end else begin
			// Hold the current request until it has been taken
			if (!samples_if.valid || in_taken) begin
				if (send_gap > 0) begin
					send_gap--;
					samples_if.valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					req = pending_samples.pop_front();
					samples_if.valid  <= 1'b1;
					samples_if.axis   <= req.axis;
					samples_if.sample <= req.sample;
					if (send_burst > 0) begin
						send_burst--;
					end else begin
						send_burst = $urandom_range(1, 12);
						send_gap   = (gap_level == 0) ? 0 : $urandom_range(0, gap_level);
					end
				end else begin
					samples_if.valid <= 1'b0;
				end
			end
			if (rx_open > 0) begin
				rx_open--;
				results_if.ready <= 1'b1;
			end else if (rx_stall > 0) begin
				rx_stall--;
				results_if.ready <= 1'b0;
			end else begin
				rx_open  = $urandom_range(1, 16);
				rx_stall = (stall_level == 0) ? 0 : $urandom_range(0, stall_level);
				results_if.ready <= 1'b1;
			end
		end
	end

	// Monitor: check results first, since a result never belongs to a request
	// accepted at the same edge; then predict the newly accepted request.
	always @(posedge clk) begin : monitor
		avg_result_t want;
		avg_result_t got;
		in_taken <= arst_n && samples_if.valid && samples_if.ready;
		if (arst_n) begin
			if (results_if.valid && results_if.ready) begin
				got.axis_out        = results_if.axis_out;
				got.average_eighths = results_if.average_eighths;
				results_seen++;
				if (expected_averages.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected result: axis_out %0d average_eighths %0d",
							got.axis_out, got.average_eighths);
				end else begin
					want = expected_averages.pop_front();
					if (got.axis_out !== want.axis_out
							|| got.average_eighths !== want.average_eighths) begin
						error_count++;
						if (error_count <= 10)
							$display({"mismatch: axis_out %0d (exp %0d) ",
								"average_eighths %0d (exp %0d)"},
								got.axis_out, want.axis_out,
								got.average_eighths, want.average_eighths);
					end
				end
			end
			if (samples_if.valid && samples_if.ready) begin
				items_accepted++;
				if (samples_if.axis >= AXES) offaxis_seen++;
				expected_averages.push_back(trim_average(samples_if.axis, samples_if.sample));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("trimmed_window_average_filter_tb: errors");
			$finish;
		end
	end

	initial begin : stimulus
		logic signed [twaf_pkg::OFFSET_W-1:0] setting [AXES];
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = twaf_pkg::REG_OFFSET_X;
		cfg_data  = '0;
		samples_if.valid  = 1'b0;
		samples_if.axis   = twaf_pkg::AXIS_X;
		samples_if.sample = '0;
		results_if.ready  = 1'b0;
		foreach (axis_offset[a]) axis_offset[a] = '0;
		foreach (axis_history[a, k]) axis_history[a][k] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int phase = 0; phase < PHASES; phase++) begin
			// Pick this phase's pacing; the first phase runs with no idling at all
			case (phase)
				0: begin gap_level = 0;  stall_level = 0;  end
				1: begin gap_level = 4;  stall_level = 3;  end
				2: begin gap_level = 15; stall_level = 0;  end
				3: begin gap_level = 0;  stall_level = 20; end
				4: begin gap_level = 8;  stall_level = 8;  end
				default: begin gap_level = 20; stall_level = 30; end
			endcase
			if (phase > 0) begin
				// Reprogram all offsets: the two extreme settings, then random ones
				if (phase == 1) setting = '{13'sh0FFF, 13'sh1000, 13'sh0000};
				else if (phase == 2) setting = '{13'sh1000, 13'sh0FFF, 13'sh1FFF};
				else foreach (setting[a]) setting[a] = twaf_pkg::OFFSET_W'($urandom());
				write_offset(twaf_pkg::REG_OFFSET_X, setting[twaf_pkg::AXIS_X]);
				write_offset(twaf_pkg::REG_OFFSET_Y, setting[twaf_pkg::AXIS_Y]);
				write_offset(twaf_pkg::REG_OFFSET_Z, setting[twaf_pkg::AXIS_Z]);
				settings_used++;
			end
			if (phase == 0) begin
				// Zero window with a zero sample: every value ties
				queue_sample(twaf_pkg::AXIS_Z, 16'sh0000);
				repeat (3) queue_sample(twaf_pkg::AXIS_X, 16'sh7FFF);
				repeat (2) queue_sample(twaf_pkg::AXIS_X, 16'sh8000);
				queue_sample(twaf_pkg::AXIS_X, 16'sh0000);
				queue_sample(twaf_pkg::AXIS_Y, 16'shFFFF);
				queue_sample(twaf_pkg::AXIS_Y, 16'sh0001);
				queue_sample(twaf_pkg::AXIS_Y, 16'sh8000);
				queue_sample(twaf_pkg::AXIS_Z, 16'sh5A5A);
				// No window on this axis: answered with zero, histories untouched
				queue_sample(AXIS_NONE, 16'sh7FFF);
				queue_sample(AXIS_NONE, 16'sh8000);
				queue_sample(twaf_pkg::AXIS_X, 16'sh7FFF);
			end else if (phase == 1) begin
				// Largest and smallest corrected values: full-scale samples plus extreme offsets
				repeat (4) queue_sample(twaf_pkg::AXIS_X, 16'sh7FFF);
				repeat (4) queue_sample(twaf_pkg::AXIS_Y, 16'sh8000);
				queue_sample(twaf_pkg::AXIS_Z, 16'sh7FFF);
				queue_sample(AXIS_NONE, 16'sh0000);
			end
			if (phase > 0) queue_random_runs(RANDOM_ITEMS_PER_PHASE);
			drain();
		end

		$display("covered %0d requests (%0d on the unmapped axis) under %0d offset settings",
			items_accepted, offaxis_seen, settings_used);
		$display("compared %0d results, %0d failures", results_seen, error_count);
		if (error_count == 0 && expected_averages.size() == 0) begin
			$display("trimmed_window_average_filter_tb: clean");
		end else begin
			$display("trimmed_window_average_filter_tb: errors");
		end
		$finish;
	end

endmodule
